// File: rtl/min_heap_priority_queue_unit_assert.svh
// Assertion macros for the min-heap priority queue.
// Included by the top level; no other dependencies.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mhpq assertion failed");
`define MHPQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    `MHPQ_ASSERT(lbl, clk, rst_n, (pre) |-> (post))
`else
`define MHPQ_ASSERT(lbl, clk, rst_n, prop)
`define MHPQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/mhpq_pkg.sv
// Shared types, codes and helpers for the min-heap priority queue.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int KEY_W = 32;
    localparam int SRC_W = 8;
    localparam int POS_W = 16;
    localparam int ENTRY_W = KEY_W + SRC_W + POS_W;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef logic signed [KEY_W-1:0] key_t;

    // packed so that key sits in the low bits, as on the stream
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [SRC_W-1:0] src;
        key_t             key;
    } entry_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    function automatic logic key_lt(input key_t a, input key_t b);
        return a < b;
    endfunction

endpackage

// File: rtl/min_heap_priority_queue_unit.sv
// Binary min-heap priority queue: heap array in one synchronous RAM,
// sift-up / sift-down sequencer and a registered result stage.
// Depends on mhpq_pkg and min_heap_priority_queue_unit_assert.svh.
`include "min_heap_priority_queue_unit_assert.svh"

// One operation per item: opcode in s_tuser selects insert or extract-min.
// Every item yields exactly one result item on the master side. The heap
// lives in a single-port-read, single-port-write RAM with a registered read
// port, so each level of a sift costs RAM round trips. An insert climbs
// at most log2(CAPACITY) levels, reading the parent and comparing per level,
// until a parent stops it or it reaches the root; an extract reads the root
// and the last entry, then sinks the moved entry (left child read, right
// child read, compare and write back per level) until the child compare
// stops it or it reaches a leaf. An error item (extract on empty, insert on
// full) goes straight to the result stage. The input is taken again as soon
// as the sequencer is idle, even while the previous result still waits in
// the output register. No clearing pass: reset only empties the entry count.
module min_heap_priority_queue_unit #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int OUT_BITS = mhpq_pkg::ENTRY_W + mhpq_pkg::STATUS_W + CW,
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_value[31:0], source_id[39:32], position_tag[55:40]
    input  logic [mhpq_pkg::ENTRY_W-1:0]  s_tdata,
    // opcode[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // min_key[31:0], min_source[39:32], min_position[55:40], status[57:56],
    // occupancy from bit 58 up, zero padded to whole bytes
    output logic [OUT_W-1:0]              m_tdata
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_UP_RD   = 9'b000000010,
        ST_UP_CMP  = 9'b000000100,
        ST_DN_ROOT = 9'b000001000,
        ST_DN_LAST = 9'b000010000,
        ST_DN_RDL  = 9'b000100000,
        ST_DN_RDR  = 9'b001000000,
        ST_DN_CMP  = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]          idx_reg, idx_next;
    mhpq_pkg::entry_t       cur_reg, cur_next;
    mhpq_pkg::entry_t       best_reg, best_next;
    logic [IW-1:0]          best_idx_reg, best_idx_next;
    logic                   moved_reg, moved_next;
    logic                   r_ok_reg, r_ok_next;
    mhpq_pkg::entry_t       res_entry_reg, res_entry_next;
    mhpq_pkg::status_t      res_status_reg, res_status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    mhpq_pkg::entry_t       heap_mem [CAPACITY];
    mhpq_pkg::entry_t       rd_data_reg;
    logic                   mem_rd_en, mem_wr_en;
    logic [IW-1:0]          mem_rd_addr, mem_wr_addr;
    mhpq_pkg::entry_t       mem_wr_data;

    logic                   accept;
    logic                   out_load;
    mhpq_pkg::entry_t       in_entry;
    logic [IW:0]            left_w, right_w, n_w;
    logic [IW-1:0]          parent_idx;
    mhpq_pkg::entry_t       sel_entry;
    logic [IW-1:0]          sel_idx;
    logic                   sel_moved;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_entry = mhpq_pkg::entry_t'(s_tdata);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign left_w     = {idx_reg, 1'b1};
    assign right_w    = left_w + (IW+1)'(1);
    assign n_w        = (IW+1)'(cnt_reg);
    assign parent_idx = IW'((idx_reg - IW'(1)) >> 1);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // right child pick on top of the left-child decision
    always_comb
    begin
        sel_entry = best_reg;
        sel_idx   = best_idx_reg;
        sel_moved = moved_reg;
        if (r_ok_reg && mhpq_pkg::key_lt(rd_data_reg.key, best_reg.key))
        begin
            sel_entry = rd_data_reg;
            sel_idx   = right_w[IW-1:0];
            sel_moved = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        moved_next      = moved_reg;
        r_ok_next       = r_ok_reg;
        res_entry_next  = res_entry_reg;
        res_status_next = res_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // root read is speculative; harmless for inserts
                mem_rd_en = 1'b1;
                if (accept)
                begin
                    res_entry_next  = '0;
                    res_status_next = mhpq_pkg::STATUS_OK;
                    if (s_tuser == mhpq_pkg::OP_INSERT)
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            res_status_next = mhpq_pkg::STATUS_FULL;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            cur_next   = in_entry;
                            idx_next   = IW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = ST_DN_ROOT;
                        end
                    end
                end
            end
            ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr_en  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = parent_idx;
                    state_next  = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                mem_wr_en = 1'b1;
                if (mhpq_pkg::key_lt(cur_reg.key, rd_data_reg.key))
                begin
                    // parent moves down into the hole
                    mem_wr_data = rd_data_reg;
                    idx_next    = parent_idx;
                    state_next  = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DN_ROOT:
            begin
                res_entry_next = rd_data_reg;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = IW'(cnt_reg);
                state_next     = ST_DN_LAST;
            end
            ST_DN_LAST:
            begin
                cur_next   = rd_data_reg;
                idx_next   = '0;
                state_next = (cnt_reg == '0) ? ST_OUT : ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                if (left_w >= n_w)
                begin
                    mem_wr_en  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = left_w[IW-1:0];
                    state_next  = ST_DN_RDR;
                end
            end
            ST_DN_RDR:
            begin
                if (mhpq_pkg::key_lt(rd_data_reg.key, cur_reg.key))
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = left_w[IW-1:0];
                    moved_next    = 1'b1;
                end
                else
                begin
                    best_next     = cur_reg;
                    best_idx_next = idx_reg;
                    moved_next    = 1'b0;
                end
                r_ok_next = (right_w < n_w);
                if (right_w < n_w)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = right_w[IW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                mem_wr_en = 1'b1;
                if (sel_moved)
                begin
                    // smaller child moves up into the hole
                    mem_wr_data = sel_entry;
                    idx_next    = sel_idx;
                    state_next  = ST_DN_RDL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({cnt_reg, res_status_reg, res_entry_reg});
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        moved_reg      <= moved_next;
        r_ok_reg       <= r_ok_next;
        res_entry_reg  <= res_entry_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            heap_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= heap_mem[mem_rd_addr];
        end
    end

    // the sequencer never reads an entry in the cycle it is rewritten
    `MHPQ_ASSERT_IMPL(a_no_rw_same_entry, clk, rst_n, mem_rd_en && mem_wr_en,
        mem_rd_addr != mem_wr_addr)
    `MHPQ_ASSERT(a_count_in_range, clk, rst_n, cnt_reg <= CW'(CAPACITY))
    `MHPQ_ASSERT_IMPL(a_empty_result_zero, clk, rst_n,
        m_tvalid && (m_tdata[mhpq_pkg::ENTRY_W +: 2] == mhpq_pkg::STATUS_EMPTY),
        m_tdata[OUT_BITS-1:mhpq_pkg::ENTRY_W + 2] == '0)
    `MHPQ_ASSERT_IMPL(a_full_result_cap, clk, rst_n,
        m_tvalid && (m_tdata[mhpq_pkg::ENTRY_W +: 2] == mhpq_pkg::STATUS_FULL),
        m_tdata[OUT_BITS-1:mhpq_pkg::ENTRY_W + 2] == CW'(CAPACITY))

endmodule

// File: dv/min_heap_priority_queue_unit_tb.sv
// Testbench for min_heap_priority_queue_unit: drives insert and extract-min items,
// predicts every result with a local heap model and checks them in order.
// Depends on mhpq_pkg and the RTL top level.
`timescale 1ns / 100ps

module min_heap_priority_queue_unit_tb;

    localparam int CAP = 64;
    localparam int OCC_W = $clog2(CAP + 1);
    localparam int OUT_W = ((mhpq_pkg::ENTRY_W + mhpq_pkg::STATUS_W + OCC_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES = 50;

    typedef struct {
        mhpq_pkg::key_t    key;
        logic [7:0]        src;
        logic [15:0]       pos;
        mhpq_pkg::status_t status;
        logic [6:0]        occ;
    } heap_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mhpq_pkg::ENTRY_W-1:0] s_tdata;
    logic                         s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [OUT_W-1:0]             m_tdata;

    // heap model state
    mhpq_pkg::entry_t heap_mem [CAP];
    int               heap_size;

    heap_result_t pending_results[$];
    int mismatch_count;
    int stall_cycles;
    bit steady;
    int hold_req;
    int hold_left;

    min_heap_priority_queue_unit #(.CAPACITY(CAP)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic heap_model_apply(input logic op, input mhpq_pkg::entry_t ent,
                                    output heap_result_t res);
        int i;
        int p;
        int l;
        int r;
        int s;
        mhpq_pkg::entry_t t;
        res.key = '0;
        res.src = '0;
        res.pos = '0;
        res.status = mhpq_pkg::STATUS_OK;
        if (op == mhpq_pkg::OP_INSERT)
        begin
            if (heap_size >= CAP)
                res.status = mhpq_pkg::STATUS_FULL;
            else
            begin
                i = heap_size;
                heap_mem[i] = ent;
                heap_size++;
                while (i != 0)
                begin
                    p = (i - 1) / 2;
                    if (!($signed(heap_mem[i].key) < $signed(heap_mem[p].key)))
                        break;
                    t = heap_mem[i];
                    heap_mem[i] = heap_mem[p];
                    heap_mem[p] = t;
                    i = p;
                end
            end
        end
        else
        begin
            if (heap_size == 0)
                res.status = mhpq_pkg::STATUS_EMPTY;
            else
            begin
                res.key = heap_mem[0].key;
                res.src = heap_mem[0].src;
                res.pos = heap_mem[0].pos;
                heap_size--;
                heap_mem[0] = heap_mem[heap_size];
                i = 0;
                while (1)
                begin
                    l = 2 * i + 1;
                    r = 2 * i + 2;
                    s = i;
                    if (l < heap_size && $signed(heap_mem[l].key) < $signed(heap_mem[s].key))
                        s = l;
                    if (r < heap_size && $signed(heap_mem[r].key) < $signed(heap_mem[s].key))
                        s = r;
                    if (s == i)
                        break;
                    t = heap_mem[i];
                    heap_mem[i] = heap_mem[s];
                    heap_mem[s] = t;
                    i = s;
                end
            end
        end
        res.occ = heap_size[6:0];
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic op, input mhpq_pkg::key_t key,
                             input logic [7:0] src, input logic [15:0] pos);
        mhpq_pkg::entry_t ent;
        heap_result_t res;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        ent.key = key;
        ent.src = src;
        ent.pos = pos;
        s_tdata  <= ent;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        heap_model_apply(op, ent, res);
        pending_results.push_back(res);
        @(negedge clk);
    endtask

    function automatic mhpq_pkg::key_t rand_key();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $signed($urandom_range(0, 6)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int insert_pct);
        logic op;
        op = ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::OP_INSERT : mhpq_pkg::OP_EXTRACT;
        // extract payload is random noise
        send_item(op, rand_key(), 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", m_tdata[31:0], 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.key)
                    report_mismatch("min_key", m_tdata[31:0], want.key);
                if (m_tdata[39:32] !== want.src)
                    report_mismatch("min_source", 32'(m_tdata[39:32]), 32'(want.src));
                if (m_tdata[55:40] !== want.pos)
                    report_mismatch("min_position", 32'(m_tdata[55:40]), 32'(want.pos));
                if (m_tdata[57:56] !== want.status)
                    report_mismatch("status", 32'(m_tdata[57:56]), 32'(want.status));
                if (m_tdata[64:58] !== want.occ)
                    report_mismatch("occupancy", 32'(m_tdata[64:58]), 32'(want.occ));
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_req > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_req - 1;
            hold_req = 0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_empty_extract();
        send_item(mhpq_pkg::OP_EXTRACT, $urandom, 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic test_key_extremes();
        send_item(mhpq_pkg::OP_INSERT, 32'sh7fffffff, 8'hff, 16'hffff);
        send_item(mhpq_pkg::OP_INSERT, 32'sh80000000, 8'h00, 16'h0000);
        send_item(mhpq_pkg::OP_INSERT, 32'sh0, 8'h5a, 16'ha5a5);
        send_item(mhpq_pkg::OP_INSERT, -32'sd1, 8'ha5, 16'h5a5a);
        send_item(mhpq_pkg::OP_INSERT, 32'sd1, 8'h01, 16'h0001);
        repeat (6)
            send_item(mhpq_pkg::OP_EXTRACT, 32'sh0, 8'h00, 16'h0000);
    endtask

    // equal keys must come out in strict array-heap order
    task automatic test_equal_keys();
        for (int i = 1; i <= 6; i++)
            send_item(mhpq_pkg::OP_INSERT, 32'sd5, i[7:0], 16'h1000 + i[15:0]);
        repeat (6)
            send_item(mhpq_pkg::OP_EXTRACT, 32'sh0, 8'h00, 16'h0000);
    endtask

    task automatic test_fill_and_drain();
        wait_results_drained();
        repeat (CAP + 2)
            send_random(100);
        repeat (CAP + 2)
            send_random(0);
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        hold_req = HOLD_CYCLES;
        repeat (30)
            send_random(60);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (150)
            send_random(55);
        steady = 1'b0;
    endtask

    task automatic test_random_phases();
        int sent;
        int len;
        int pct;
        sent = 0;
        while (sent < 560)
        begin
            len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: pct = 85;
                1: pct = 15;
                default: pct = 50;
            endcase
            repeat (len)
                send_random(pct);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mhpq_pkg::OP_INSERT;
        heap_size = 0;
        mismatch_count = 0;
        steady = 1'b0;
        hold_req = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_extract();
        test_key_extremes();
        test_equal_keys();
        test_fill_and_drain();
        test_output_backpressure();
        test_steady_stream();
        test_random_phases();
        test_fill_and_drain();

        wait_results_drained();
        repeat (END_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/min_heap_priority_queue_unit.sv
dv/min_heap_priority_queue_unit_tb.sv
